// ----- design/fbfsa_pkg.sv -----
// Shared constants, codes and widths for the fixed-size block free-stack allocator.
package fbfsa_pkg;

   // Default sizing of the pool
   localparam int MAX_BLOCKS_DEF    = 1024;
   localparam int POINTER_BYTES_DEF = 8;
   localparam int ADDRESS_BITS_DEF  = 32;

   // Fixed widths of registers and item fields
   localparam int BASE_W    = 32;
   localparam int BYTES_W   = 16;
   localparam int COUNT_W   = 11;
   localparam int OUT_ADDR_W = 32;
   localparam int REL_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Register reset values
   localparam logic [BASE_W-1:0]  BASE_RESET  = '0;
   localparam logic [BYTES_W-1:0] BYTES_RESET = 16'd8;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // Operation codes of an input item
   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_REBUILD = 2'd2
   } op_type;

   // Status codes of a result item
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NULL  = 2'd3
   } status_type;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_BASE  = 2'd0,
      REG_BYTES = 2'd1,
      REG_COUNT = 2'd2
   } reg_type;

endpackage

// ----- design/fbfsa_fill.sv -----
// Rebuild sequencer: rounds the block size and walks the free stack, one entry per cycle.
module fbfsa_fill
   import fbfsa_pkg::*;
#(
   parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
   parameter int POINTER_BYTES = POINTER_BYTES_DEF,
   parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF,
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [BASE_W-1:0]       base_address,
   input  logic [BYTES_W-1:0]      block_bytes,
   input  logic [CNT_W-1:0]        capacity,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_idx,
   output logic [ADDRESS_BITS-1:0] wr_data,
   output logic                    done
);

   // Rounding by reciprocal: q = floor((bytes + P - 1) * M / 2^K)
   localparam int X_W  = BYTES_W + 1;
   localparam int K    = X_W + 5;
   localparam int M    = ((1 << K) + POINTER_BYTES - 1) / POINTER_BYTES;
   localparam int M_W  = K + 1;
   localparam int P_W  = X_W + M_W;
   localparam int SZ_W = X_W + $clog2(POINTER_BYTES + 1);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_QUOT = 4'b0010,
      F_SIZE = 4'b0100,
      F_RUN  = 4'b1000
   } fill_state_type;

   fill_state_type          state_ff, state_in;
   logic [X_W-1:0]          quot_ff, quot_in;
   logic [SZ_W-1:0]         size_ff, size_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        cap_ff, cap_in;
   logic [X_W-1:0]          bytes_up;
   logic [P_W-1:0]          product;

   assign bytes_up = X_W'(block_bytes) + X_W'(POINTER_BYTES - 1);
   assign product  = P_W'(bytes_up) * P_W'(M);

   // Sequence quotient, size, then the walk
   always_comb begin
      state_in = state_ff;
      quot_in  = quot_ff;
      size_in  = size_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      cap_in   = cap_ff;
      wr_en    = 1'b0;
      done     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               cap_in   = capacity;
               state_in = F_QUOT;
            end
         end
         F_QUOT: begin
            quot_in  = product[K +: X_W];
            state_in = F_SIZE;
         end
         F_SIZE: begin
            size_in  = SZ_W'(quot_ff) * SZ_W'(POINTER_BYTES);
            addr_in  = ADDRESS_BITS'(base_address);
            cnt_in   = '0;
            state_in = F_RUN;
         end
         F_RUN: begin
            if (cnt_ff == cap_ff) begin
               done     = 1'b1;
               state_in = F_IDLE;
            end else begin
               wr_en   = 1'b1;
               addr_in = addr_ff + ADDRESS_BITS'(size_ff);
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign wr_idx  = cnt_ff[IDX_W-1:0];
   assign wr_data = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold working values
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      cap_ff  <= cap_in;
   end

endmodule

// ----- design/fixed_block_free_stack_allocator.sv -----
// Fixed-size block allocator: a LIFO stack of free block addresses held in one memory.
//
// Each item gives one result item. Allocate pops the top address and passes through
// the read state, because the stack memory has a registered read port; release, which
// pushes an address, and an unused operation code are answered from the idle state.
// Rebuild passes through the accept cycle, a quotient step and a size step that round
// the block size up to a multiple of the pointer size, one memory write per block, and
// a finishing step. A new item is taken while idle once the result register is empty
// or is being drained in that cycle. Stack entries are not cleared after reset and the
// pool starts empty, so the block is ready at once; no entry is read before it is written.
module fixed_block_free_stack_allocator
   import fbfsa_pkg::*;
#(
   parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
   parameter int POINTER_BYTES = POINTER_BYTES_DEF,
   parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [REL_W-1:0]      req_release_address,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_ADDR_W-1:0] rsp_block_address,
   output logic [1:0]            rsp_status,
   output logic [COUNT_W-1:0]    rsp_free_blocks,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_FILL = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        top_ff, top_in;
   logic [BASE_W-1:0]       base_ff;
   logic [BYTES_W-1:0]      bytes_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_free_ff, rsp_free_in;
   logic                    out_load;

   logic [ADDRESS_BITS-1:0] stack_mem [MAX_BLOCKS];
   logic [ADDRESS_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]        rd_idx;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_idx;
   logic [ADDRESS_BITS-1:0] wr_data;

   logic                    rel_we;
   logic [ADDRESS_BITS-1:0] rel_addr;
   logic [CNT_W-1:0]        capacity;
   logic                    accept;
   logic                    csr_we;
   logic [1:0]              csr_idx;
   logic                    fill_start;
   logic                    fill_we;
   logic [IDX_W-1:0]        fill_idx;
   logic [ADDRESS_BITS-1:0] fill_data;
   logic                    fill_done;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_we     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         bytes_ff <= BYTES_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            REG_BASE:  base_ff  <= csr_pwdata[BASE_W-1:0];
            REG_BYTES: bytes_ff <= csr_pwdata[BYTES_W-1:0];
            REG_COUNT: count_ff <= csr_pwdata[COUNT_W-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BASE:  csr_prdata = CSR_DATA_W'(base_ff);
         REG_BYTES: csr_prdata = CSR_DATA_W'(bytes_ff);
         REG_COUNT: csr_prdata = CSR_DATA_W'(count_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // Clamp the block count to the stack depth
   assign capacity = (32'(count_ff) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(count_ff);

   assign rel_addr  = ADDRESS_BITS'(req_release_address);
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid & req_ready;
   assign rd_idx    = IDX_W'(top_ff - CNT_W'(1));

   // Decode the item and sequence its work
   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      out_load      = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = ST_OK;
      rsp_free_in   = COUNT_W'(top_ff);
      rel_we        = 1'b0;
      fill_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_ALLOC: begin
                     if (top_ff == '0) begin
                        out_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        top_in   = top_ff - CNT_W'(1);
                        state_in = S_READ;
                     end
                  end
                  OP_RELEASE: begin
                     out_load = 1'b1;
                     if (rel_addr == '0) begin
                        rsp_status_in = ST_NULL;
                     end else if (top_ff >= capacity) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rel_we      = 1'b1;
                        top_in      = top_ff + CNT_W'(1);
                        rsp_free_in = COUNT_W'(top_ff + CNT_W'(1));
                     end
                  end
                  OP_REBUILD: begin
                     fill_start = 1'b1;
                     state_in   = S_FILL;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            out_load    = 1'b1;
            rsp_addr_in = OUT_ADDR_W'(rd_data_ff);
            state_in    = S_IDLE;
         end
         S_FILL: begin
            if (fill_done) begin
               out_load    = 1'b1;
               top_in      = capacity;
               rsp_free_in = COUNT_W'(capacity);
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance the result register
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
         rsp_free_ff   <= rsp_free_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_blocks   = rsp_free_ff;

   // Rebuild walk
   fbfsa_fill #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .POINTER_BYTES (POINTER_BYTES),
      .ADDRESS_BITS  (ADDRESS_BITS)
   ) u_fill (
      .clock        (clock),
      .reset        (reset),
      .start        (fill_start),
      .base_address (base_ff),
      .block_bytes  (bytes_ff),
      .capacity     (capacity),
      .wr_en        (fill_we),
      .wr_idx       (fill_idx),
      .wr_data      (fill_data),
      .done         (fill_done)
   );

   // Stack memory: one write port, one registered read port
   assign wr_en   = rel_we | fill_we;
   assign wr_idx  = rel_we ? top_ff[IDX_W-1:0] : fill_idx;
   assign wr_data = rel_we ? rel_addr : fill_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem[rd_idx];
   end

endmodule

// ----- tb/tb_fixed_block_free_stack_allocator.sv -----
// Self-checking testbench for the fixed-size block free-stack allocator.
module tb_fixed_block_free_stack_allocator;
   import fbfsa_pkg::*;

   // Operation code with no meaning; the block must answer it without effect
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int HOLD_PHASE      = 2;
   localparam int HOLD_CYCLES     = 200;
   localparam int DIRECTED_LEN    = 19;

   typedef struct packed {
      logic [OUT_ADDR_W-1:0] block_address;
      logic [1:0]            status;
      logic [COUNT_W-1:0]    free_blocks;
   } alloc_result_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [31:0]       rel;
      logic              typed;
      alloc_result_type  result;
   } directed_row_type;

   // Directed items under the reset settings: base 0, 8-byte blocks, 1024 blocks
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      '{OP_ALLOC,   32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 11'd0}},
      '{OP_RELEASE, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_NULL,  11'd0}},
      '{OP_UNUSED,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    11'd0}},
      '{OP_RELEASE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    11'd1}},
      '{OP_RELEASE, 32'h0000_0001, 1'b1, '{32'h0000_0000, ST_OK,    11'd2}},
      '{OP_ALLOC,   32'h0000_0000, 1'b1, '{32'h0000_0001, ST_OK,    11'd1}},
      '{OP_ALLOC,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK,    11'd0}},
      '{OP_ALLOC,   32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 11'd0}},
      '{OP_REBUILD, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    11'd1024}},
      '{OP_RELEASE, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_FULL,  11'd1024}},
      '{OP_ALLOC,   32'h0000_0000, 1'b1, '{32'h0000_1FF8, ST_OK,    11'd1023}},
      '{OP_ALLOC,   32'h0000_0000, 1'b0, '0},
      '{OP_RELEASE, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,    11'd1023}},
      '{OP_RELEASE, 32'h5555_5555, 1'b1, '{32'h0000_0000, ST_OK,    11'd1024}},
      '{OP_RELEASE, 32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, ST_FULL,  11'd1024}},
      '{OP_ALLOC,   32'h0000_0000, 1'b0, '0},
      '{OP_ALLOC,   32'h0000_0000, 1'b0, '0},
      '{OP_UNUSED,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    11'd1022}},
      '{OP_RELEASE, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_NULL,  11'd1022}}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_operation;
   logic [REL_W-1:0]      req_release_address;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [OUT_ADDR_W-1:0] rsp_block_address;
   logic [1:0]            rsp_status;
   logic [COUNT_W-1:0]    rsp_free_blocks;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the pool: free stack, top and settings
   logic [31:0]        pool_stack [MAX_BLOCKS_DEF];
   int unsigned        pool_top;
   logic [BASE_W-1:0]  cfg_base;
   logic [BYTES_W-1:0] cfg_bytes;
   logic [COUNT_W-1:0] cfg_count;

   alloc_result_type   pending_results [$];
   logic [31:0]        handed_out [$];
   int                 error_count;
   int                 phase_num;
   bit                 calm;

   fixed_block_free_stack_allocator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Compute the result of one item and advance the shadow pool
   function automatic alloc_result_type next_pool_result(input logic [1:0] op,
                                                         input logic [31:0] rel);
      alloc_result_type r;
      int unsigned      cap;
      int unsigned      step;
      int unsigned      k;
      r = '0;
      r.status = ST_OK;
      cap = (cfg_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : 32'(cfg_count);
      case (op)
         OP_ALLOC: begin
            if (pool_top == 0) begin
               r.status = ST_EMPTY;
            end else begin
               pool_top--;
               r.block_address = pool_stack[pool_top];
            end
         end
         OP_RELEASE: begin
            if (rel == 32'd0) begin
               r.status = ST_NULL;
            end else if (pool_top >= cap) begin
               r.status = ST_FULL;
            end else begin
               pool_stack[pool_top] = rel;
               pool_top++;
            end
         end
         OP_REBUILD: begin
            // Round the block size up to a whole number of pointers
            step = 32'(cfg_bytes);
            if (step % POINTER_BYTES_DEF != 0)
               step = step + POINTER_BYTES_DEF - step % POINTER_BYTES_DEF;
            for (k = 0; k < cap; k++)
               pool_stack[k] = cfg_base + k * step;
            pool_top = cap;
         end
         default: ;
      endcase
      r.free_blocks = pool_top[COUNT_W-1:0];
      return r;
   endfunction

   // Offer one item, hold it until accepted, then record its expected result
   task automatic send_item(input logic [1:0] op, input logic [31:0] rel,
                            input logic typed, input alloc_result_type typed_result);
      int               gap;
      alloc_result_type predicted;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_release_address <= rel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = next_pool_result(op, rel);
      pending_results.push_back(typed ? typed_result : predicted);
      if (op == OP_ALLOC && predicted.status == ST_OK)
         handed_out.push_back(predicted.block_address);
      if (op == OP_REBUILD)
         handed_out.delete();
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic write_reg(input reg_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_BASE:  cfg_base  = value[BASE_W-1:0];
         REG_BYTES: cfg_bytes = value[BYTES_W-1:0];
         REG_COUNT: cfg_count = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      alloc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with no expectation: addr %h status %0d free %0d",
                   rsp_block_address, rsp_status, rsp_free_blocks);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_block_address !== want.block_address) begin
               $error("block_address: expected %h, got %h",
                      want.block_address, rsp_block_address);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_free_blocks !== want.free_blocks) begin
               $error("free_blocks: expected %0d, got %0d",
                      want.free_blocks, rsp_free_blocks);
               error_count++;
            end
         end
      end
   end

   // Result side: random stall bursts, one long hold-off to back up the input
   initial begin : drain_results
      int stall;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (phase_num == HOLD_PHASE && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int          ph;
      int          n;
      int          pick;
      int          slot;
      logic [1:0]  op;
      logic [31:0] rel;
      logic [31:0] base_v;
      logic [15:0] bytes_v;
      logic [10:0] count_v;

      clock = 1'b0;
      error_count = 0;
      phase_num = -1;
      calm = 1'b0;
      pool_top = 0;
      cfg_base = BASE_RESET;
      cfg_bytes = BYTES_RESET;
      cfg_count = COUNT_RESET;
      for (n = 0; n < MAX_BLOCKS_DEF; n++) pool_stack[n] = '0;

      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_operation       <= OP_ALLOC;
      req_release_address <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table under the reset settings
      for (n = 0; n < DIRECTED_LEN; n++)
         send_item(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].rel,
                   DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].result);

      // Random phases, each under its own settings and opened by a rebuild
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain_all();
         base_v  = $urandom;
         bytes_v = 16'($urandom_range(1, 100));
         count_v = 11'($urandom_range(1, 48));
         case (ph)
            0: begin base_v = 32'hFFFF_FFF0; bytes_v = 16'd1; count_v = 11'd5; end
            1: begin base_v = 32'h0; bytes_v = 16'd0; count_v = 11'd3; end
            2: begin bytes_v = 16'hFFFF; count_v = 11'd7; end
            3: begin bytes_v = 16'($urandom_range(1, 64)); count_v = 11'd0; end
            4: begin bytes_v = 16'($urandom); count_v = 11'h7FF; end
            5: begin bytes_v = 16'($urandom_range(1, 40)); count_v = 11'd1; end
            6: begin bytes_v = 16'($urandom); count_v = 11'd1024; end
            default: ;
         endcase
         write_reg(REG_BASE, base_v);
         write_reg(REG_BYTES, {16'd0, bytes_v});
         write_reg(REG_COUNT, {21'd0, count_v});
         phase_num = ph;
         send_item(OP_REBUILD, $urandom, 1'b0, '0);

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == NUM_PHASES - 1 && n >= ITEMS_PER_PHASE / 2)
               calm = 1'b1;
            pick = $urandom_range(0, 99);
            rel  = $urandom;
            if (pick < 42) begin
               op = OP_ALLOC;
            end else if (pick < 84) begin
               // Mostly hand back a block that was taken earlier
               op = OP_RELEASE;
               if (handed_out.size() != 0 && $urandom_range(0, 2) != 0) begin
                  slot = $urandom_range(0, handed_out.size() - 1);
                  rel  = handed_out[slot];
                  handed_out.delete(slot);
               end
            end else if (pick < 90) begin
               op  = OP_RELEASE;
               rel = 32'h0;
            end else if (pick < 95) begin
               op = OP_REBUILD;
            end else begin
               op = OP_UNUSED;
            end
            send_item(op, rel, 1'b0, '0);
         end
      end

      drain_all();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
